// ===== src/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_HALF_BIT   = 2'd0;
   localparam logic [1:0] CSR_SETUP_HOLD = 2'd1;
   localparam logic [1:0] CSR_ACK_TMO    = 2'd2;

   localparam logic [7:0] HALF_BIT_RESET   = 8'd2;
   localparam logic [7:0] SETUP_HOLD_RESET = 8'd4;
   localparam logic [7:0] ACK_TMO_RESET    = 8'd250;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_START     = 3'd1,
      OP_STOP      = 3'd2,
      OP_WRITE     = 3'd3,
      OP_READ_ACK  = 3'd4,
      OP_READ_NACK = 3'd5,
      OP_WAIT_ACK  = 3'd6
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST1     = 5'd1,
      PH_ST2     = 5'd2,
      PH_ST3     = 5'd3,
      PH_SP1     = 5'd4,
      PH_SP2     = 5'd5,
      PH_SP3     = 5'd6,
      PH_WR_SET  = 5'd7,
      PH_WR_HIGH = 5'd8,
      PH_WR_LOW  = 5'd9,
      PH_RD_LOW  = 5'd10,
      PH_RD_HIGH = 5'd11,
      PH_AK_SET  = 5'd12,
      PH_AK_HIGH = 5'd13,
      PH_AK_LOW  = 5'd14,
      PH_WA_REL  = 5'd15,
      PH_WA_HIGH = 5'd16,
      PH_WA_POLL = 5'd17,
      PH_WA_LOW  = 5'd18
   } phase_type;

   typedef struct packed {
      logic [7:0] half_bit;
      logic [7:0] setup_hold;
      logic [7:0] ack_tmo;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] bit_count;
      logic [7:0] shift_reg;
      logic [7:0] tick_count;
      logic       scl;
      logic       sda;
      logic       drive;
      logic       fail;
      logic [7:0] read_hold;
      logic       nack_bit;
   } state_type;

   // Enter a timed segment: restart the tick count and set the line levels.
   function automatic state_type enter_phase(state_type s, phase_type p);
      state_type r;
      r            = s;
      r.phase      = p;
      r.tick_count = 8'd1;
      unique case (p)
         PH_ST1:     begin r.scl = 1'b1; r.sda = 1'b1; r.drive = 1'b1; end
         PH_ST2:     begin r.scl = 1'b1; r.sda = 1'b0; r.drive = 1'b1; end
         PH_ST3:     begin r.scl = 1'b0; r.sda = 1'b0; r.drive = 1'b1; end
         PH_SP1:     begin r.scl = 1'b0; r.sda = 1'b0; r.drive = 1'b1; end
         PH_SP2:     begin r.scl = 1'b1; r.sda = 1'b0; r.drive = 1'b1; end
         PH_SP3:     begin r.scl = 1'b1; r.sda = 1'b1; r.drive = 1'b1; end
         PH_WR_SET:  begin r.scl = 1'b0; r.sda = s.shift_reg[7]; r.drive = 1'b1; end
         PH_RD_LOW:  begin r.scl = 1'b0; r.sda = 1'b1; r.drive = 1'b0; end
         PH_AK_SET:  begin r.scl = 1'b0; r.sda = s.nack_bit; r.drive = 1'b1; end
         PH_WA_REL:  begin r.scl = 1'b0; r.sda = 1'b1; r.drive = 1'b0; end
         PH_WA_POLL: begin r.scl = 1'b1; r.tick_count = 8'd0; end
         PH_WR_HIGH, PH_RD_HIGH, PH_AK_HIGH, PH_WA_HIGH: r.scl = 1'b1;
         PH_WR_LOW, PH_AK_LOW, PH_WA_LOW:                r.scl = 1'b0;
         default: r.tick_count = 8'd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/i2cbm_step.sv =====
`default_nettype none

// One bus tick: next sequencer state from the current one and the request.
module i2cbm_step (
   input  var i2cbm_pkg::state_type cur,
   input  var i2cbm_pkg::cfg_type   cfg,
   input  var i2cbm_pkg::op_type    op,
   input  var logic [7:0]           write_byte,
   input  var logic                 sda_sample,
   output i2cbm_pkg::state_type     nxt,
   output logic                     done
);

   i2cbm_pkg::state_type base;
   logic [7:0]           dur;
   logic [7:0]           shifted;
   logic                 start_stop;

   assign start_stop = (cur.phase == i2cbm_pkg::PH_ST1) || (cur.phase == i2cbm_pkg::PH_ST2) ||
                       (cur.phase == i2cbm_pkg::PH_ST3) || (cur.phase == i2cbm_pkg::PH_SP1) ||
                       (cur.phase == i2cbm_pkg::PH_SP2) || (cur.phase == i2cbm_pkg::PH_SP3);
   assign dur     = start_stop ? cfg.setup_hold : cfg.half_bit;
   assign shifted = {cur.shift_reg[6:0], sda_sample};

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      base = cur;
      if (cur.phase == i2cbm_pkg::PH_IDLE) begin
         base.fail      = 1'b0;
         base.bit_count = 3'd0;
         unique case (op)
            i2cbm_pkg::OP_START: nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_ST1);
            i2cbm_pkg::OP_STOP:  nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_SP1);
            i2cbm_pkg::OP_WRITE: begin
               base.shift_reg = write_byte;
               nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_WR_SET);
            end
            i2cbm_pkg::OP_READ_ACK, i2cbm_pkg::OP_READ_NACK: begin
               base.nack_bit  = (op == i2cbm_pkg::OP_READ_NACK);
               base.shift_reg = 8'd0;
               nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_RD_LOW);
            end
            i2cbm_pkg::OP_WAIT_ACK: nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_WA_REL);
            default: nxt = cur;   // no op, or an unused code
         endcase
      end else if (cur.phase == i2cbm_pkg::PH_WA_POLL) begin
         // ACK poll: low sample ends, too many high samples abort with a stop
         if (!sda_sample) begin
            nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_WA_LOW);
         end else if (cur.tick_count >= cfg.ack_tmo) begin
            base.fail = 1'b1;
            nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_SP1);
         end else begin
            nxt.tick_count = cur.tick_count + 8'd1;
         end
      end else if (cur.tick_count < dur) begin
         nxt.tick_count = cur.tick_count + 8'd1;
      end else begin
         unique case (cur.phase)
            i2cbm_pkg::PH_WR_LOW: begin
               if (cur.bit_count == i2cbm_pkg::LAST_BIT) begin
                  nxt.phase = i2cbm_pkg::PH_IDLE;
                  done      = 1'b1;
               end else begin
                  base.bit_count = cur.bit_count + 3'd1;
                  base.shift_reg = {cur.shift_reg[6:0], 1'b0};
                  nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_WR_SET);
               end
            end
            i2cbm_pkg::PH_RD_HIGH: begin
               base.shift_reg = shifted;
               if (cur.bit_count == i2cbm_pkg::LAST_BIT) begin
                  base.read_hold = shifted;
                  nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_AK_SET);
               end else begin
                  base.bit_count = cur.bit_count + 3'd1;
                  nxt = i2cbm_pkg::enter_phase(base, i2cbm_pkg::PH_RD_LOW);
               end
            end
            i2cbm_pkg::PH_ST1:     nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_ST2);
            i2cbm_pkg::PH_ST2:     nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_ST3);
            i2cbm_pkg::PH_SP1:     nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_SP2);
            i2cbm_pkg::PH_SP2:     nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_SP3);
            i2cbm_pkg::PH_WR_SET:  nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_WR_HIGH);
            i2cbm_pkg::PH_WR_HIGH: nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_WR_LOW);
            i2cbm_pkg::PH_RD_LOW:  nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_RD_HIGH);
            i2cbm_pkg::PH_AK_SET:  nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_AK_HIGH);
            i2cbm_pkg::PH_AK_HIGH: nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_AK_LOW);
            i2cbm_pkg::PH_WA_REL:  nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_WA_HIGH);
            i2cbm_pkg::PH_WA_HIGH: nxt = i2cbm_pkg::enter_phase(cur, i2cbm_pkg::PH_WA_POLL);
            default: begin
               // final segments (start, stop, ack, wait-ack) and stray codes
               nxt.phase = i2cbm_pkg::PH_IDLE;
               done      = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/i2c_byte_command_master_core.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/req_tready one bus tick: op, write byte, SDA sample
// rsp       out        rsp_tvalid/rsp_tready line levels and status after the tick
// csr       in         csr_valid/csr_ready   register index and 8-bit value
//
// Every accepted request is one bus tick and yields exactly one response.
// The tick is worked out combinationally from the sequencer state; the response
// register shows it the cycle after; with no rsp stall, a request per cycle is taken.
// req_tready drops only while a response sits unread in the output register.
// csr_ready is always high; writes are meant to land between commands.
// Synchronous reset: bus idle high, sequencer idle, registers at defaults.
module i2c_byte_command_master_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: op[2:0], write_byte[10:3], sda_sample[11], zero pad [15:12]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // rsp_tdata: scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
   //            done_res[4], read_byte[12:5], ack_failed[13], zero pad [15:14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   i2cbm_pkg::cfg_type   cfg_ff;
   i2cbm_pkg::state_type state_ff;
   i2cbm_pkg::state_type state_in;
   logic                 done;
   logic                 req_accept;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [15:0]          rsp_data_ff;
   logic [15:0]          rsp_data_in;

   // Output register frees up when empty or being read this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit   <= i2cbm_pkg::HALF_BIT_RESET;
         cfg_ff.setup_hold <= i2cbm_pkg::SETUP_HOLD_RESET;
         cfg_ff.ack_tmo    <= i2cbm_pkg::ACK_TMO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            i2cbm_pkg::CSR_HALF_BIT:   cfg_ff.half_bit   <= csr_data;
            i2cbm_pkg::CSR_SETUP_HOLD: cfg_ff.setup_hold <= csr_data;
            i2cbm_pkg::CSR_ACK_TMO:    cfg_ff.ack_tmo    <= csr_data;
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   i2cbm_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .op         (i2cbm_pkg::op_type'(req_tdata[2:0])),
      .write_byte (req_tdata[10:3]),
      .sda_sample (req_tdata[11]),
      .nxt        (state_in),
      .done       (done)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, state_in.fail, state_in.read_hold, done,
                         state_in.phase != i2cbm_pkg::PH_IDLE,
                         state_in.drive, state_in.sda, state_in.scl};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= i2cbm_pkg::PH_IDLE;
         state_ff.bit_count  <= 3'd0;
         state_ff.shift_reg  <= 8'd0;
         state_ff.tick_count <= 8'd0;
         state_ff.scl        <= 1'b1;
         state_ff.sda        <= 1'b1;
         state_ff.drive      <= 1'b1;
         state_ff.fail       <= 1'b0;
         state_ff.read_hold  <= 8'd0;
         state_ff.nack_bit   <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // No response may be pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // The sequencer only moves on an accepted request
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("sequencer state changed without a request");

   // The failure flag is raised only by an ACK poll timing out
   assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.fail) |-> $past(state_ff.phase) == i2cbm_pkg::PH_WA_POLL)
      else $error("ack failure set outside the ACK poll");

   // SDA is released only in read and wait-for-ACK segments, and stays
   // released in idle after an acknowledged wait
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.drive |-> (state_ff.phase == i2cbm_pkg::PH_RD_LOW ||
                           state_ff.phase == i2cbm_pkg::PH_RD_HIGH ||
                           state_ff.phase == i2cbm_pkg::PH_WA_REL ||
                           state_ff.phase == i2cbm_pkg::PH_WA_HIGH ||
                           state_ff.phase == i2cbm_pkg::PH_WA_POLL ||
                           state_ff.phase == i2cbm_pkg::PH_WA_LOW ||
                           state_ff.phase == i2cbm_pkg::PH_IDLE))
      else $error("SDA released outside a read or ACK wait");
`endif

endmodule

`default_nettype wire
